@@ rtl/core/msk_pkg.sv @@
package msk_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_FIN,
      ST_SCAN
   } state_type;

   localparam int unsigned GROUP_BITS = 7;
   localparam logic [GROUP_BITS-1:0] GROUP_RESET = 7'd2;

endpackage

@@ rtl/core/min_spread_of_k_values.sv @@
// Sorts a set of unsigned words as they arrive and, after the last word of
// the set, returns the smallest (max - min) over any group_size of them.
// req_*: one value word per handshake; req_last_value closes the set.
// rsp_*: one result word per set: rsp_min_spread, and rsp_too_few when the
//   set held fewer values than group_size (spread then reads 0).
// csr_*: group_size is written with csr_we; write it only while idle.
//   A group size of 0 acts as 1. Values beyond MAX_ITEMS are dropped.
// Insertion: the store is one RAM (duplicated for a second read port)
//   with a registered read. A word into an empty store is written directly;
//   else each larger stored value is moved up one slot, then the word is placed.
// Scan: a setup state, then one window per cycle (count - k + 1 windows)
//   through both read ports, a drain step, then the result is registered.
// The result sits in an output register; the next set is accepted while it
//   waits. A second result waits in the scan state until rsp_ready frees it.
// Reset: group_size = 2, store empty, no result pending.
module min_spread_of_k_values #(
   parameter int unsigned MAX_ITEMS  = 64,
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_last_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_min_spread,
   output logic                  rsp_too_few,
   input  logic                  csr_we,
   input  logic [msk_pkg::GROUP_BITS-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned WW = (CW > msk_pkg::GROUP_BITS) ? CW : msk_pkg::GROUP_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

   msk_pkg::state_type state_ff, state_in;

   logic [msk_pkg::GROUP_BITS-1:0] group_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  last_ff, last_in;
   logic [CW-1:0]         scan_i_ff, scan_i_in;
   logic [CW-1:0]         scan_last_ff, scan_last_in;
   logic [AW-1:0]         scan_off_ff, scan_off_in;
   logic                  more_ff, more_in;
   logic                  pvld_ff, pvld_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic                  few_ff, few_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_spread_ff, rsp_spread_in;
   logic                  rsp_few_ff, rsp_few_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic [AW-1:0]         raddr_a, raddr_b;
   logic [VALUE_BITS-1:0] rd_a, rd_b;

   logic [CW-1:0]         count_m1, pos_m1, pos_m2;
   logic [WW-1:0]         k_ext, count_ext, last_ext, off_ext;
   logic [VALUE_BITS-1:0] diff;
   logic                  accept, full, scan_done, rsp_free;

   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign count_m1  = count_ff - CW'(1);
   assign pos_m1    = pos_ff - CW'(1);
   assign pos_m2    = pos_ff - CW'(2);
   assign k_ext     = (group_ff == '0) ? WW'(1) : WW'(group_ff);
   assign count_ext = WW'(count_ff);
   assign last_ext  = count_ext - k_ext;
   assign off_ext   = k_ext - WW'(1);
   assign diff      = rd_b - rd_a;
   assign scan_done = !more_ff && !pvld_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   msk_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram_a (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (raddr_a),
      .rdata (rd_a)
   );

   // copy of the store for the upper end of each window
   msk_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram_b (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (raddr_b),
      .rdata (rd_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msk_pkg::ST_IDLE: begin
            if (accept) begin
               if (full || count_ff == '0) begin
                  state_in = req_last_value ? msk_pkg::ST_FIN : msk_pkg::ST_IDLE;
               end else begin
                  state_in = msk_pkg::ST_SHIFT;
               end
            end
         end
         msk_pkg::ST_SHIFT: begin
            if (rd_a > val_ff) begin
               if (pos_m1 == '0) begin
                  state_in = msk_pkg::ST_PLACE;
               end
            end else begin
               state_in = last_ff ? msk_pkg::ST_FIN : msk_pkg::ST_IDLE;
            end
         end
         msk_pkg::ST_PLACE: begin
            state_in = last_ff ? msk_pkg::ST_FIN : msk_pkg::ST_IDLE;
         end
         msk_pkg::ST_FIN: begin
            state_in = msk_pkg::ST_SCAN;
         end
         msk_pkg::ST_SCAN: begin
            if (scan_done && rsp_free) begin
               state_in = msk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msk_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      scan_i_in     = scan_i_ff;
      scan_last_in  = scan_last_ff;
      scan_off_in   = scan_off_ff;
      more_in       = more_ff;
      pvld_in       = 1'b0;
      best_in       = best_ff;
      few_in        = few_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_spread_in = rsp_spread_ff;
      rsp_few_in    = rsp_few_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff[AW-1:0];
      mem_wdata     = val_ff;
      raddr_a       = count_m1[AW-1:0];
      raddr_b       = scan_i_ff[AW-1:0] + scan_off_ff;
      case (state_ff)
         msk_pkg::ST_IDLE: begin
            if (accept) begin
               val_in  = req_value;
               last_in = req_last_value;
               pos_in  = count_ff;
               if (!full && count_ff == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = req_value;
                  count_in  = CW'(1);
               end
            end
         end
         msk_pkg::ST_SHIFT: begin
            mem_we = 1'b1;
            if (rd_a > val_ff) begin
               // move the larger word up one slot, fetch the next one down
               mem_wdata = rd_a;
               pos_in    = pos_m1;
               raddr_a   = pos_m2[AW-1:0];
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         msk_pkg::ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_in  = count_ff + CW'(1);
         end
         msk_pkg::ST_FIN: begin
            few_in       = count_ext < k_ext;
            more_in      = !(count_ext < k_ext);
            best_in      = (count_ext < k_ext) ? '0 : '1;
            scan_i_in    = '0;
            scan_last_in = last_ext[CW-1:0];
            scan_off_in  = off_ext[AW-1:0];
         end
         msk_pkg::ST_SCAN: begin
            raddr_a = scan_i_ff[AW-1:0];
            if (more_ff) begin
               pvld_in   = 1'b1;
               scan_i_in = scan_i_ff + CW'(1);
               more_in   = (scan_i_ff != scan_last_ff);
            end
            if (pvld_ff && diff < best_ff) begin
               best_in = diff;
            end
            if (scan_done && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_spread_in = best_ff;
               rsp_few_in    = few_ff;
               count_in      = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msk_pkg::ST_IDLE;
         group_ff     <= msk_pkg::GROUP_RESET;
         count_ff     <= '0;
         more_ff      <= 1'b0;
         pvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         pvld_ff      <= pvld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            group_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      last_ff       <= last_in;
      scan_i_ff     <= scan_i_in;
      scan_last_ff  <= scan_last_in;
      scan_off_ff   <= scan_off_in;
      best_ff       <= best_in;
      few_ff        <= few_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_few_ff    <= rsp_few_in;
   end

   assign req_ready      = (state_ff == msk_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_spread = rsp_spread_ff;
   assign rsp_too_few    = rsp_few_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("store count beyond capacity");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msk_pkg::ST_SHIFT) |-> (pos_ff != '0))
      else $error("shift with insert position at bottom");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msk_pkg::ST_SCAN) |-> !mem_we)
      else $error("store written during scan");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (count_ff == '0))
      else $error("store not emptied after result");
`endif

endmodule

@@ rtl/core/msk_ram.sv @@
module msk_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ verif/min_spread_checker.sv @@
`timescale 1ns / 1ps
module min_spread_checker #(
   parameter int unsigned MAX_ITEMS  = 64,
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [VALUE_BITS-1:0]          req_value,
   input  logic                           req_last_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [VALUE_BITS-1:0]          rsp_min_spread,
   input  logic                           rsp_too_few,
   input  logic                           csr_we,
   input  logic [msk_pkg::GROUP_BITS-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   localparam int unsigned GROUP_BITS = msk_pkg::GROUP_BITS;

   typedef struct packed {
      logic [VALUE_BITS-1:0] spread;
      logic                  too_few;
   } spread_word_type;

   logic [VALUE_BITS-1:0] held_vals [MAX_ITEMS];
   int unsigned           held_count;
   logic [GROUP_BITS-1:0] group_size;
   spread_word_type       expected_spreads [$];

   // values past a full store are dropped
   task automatic insert_value(input logic [VALUE_BITS-1:0] v);
      int unsigned pos;
      if (held_count < MAX_ITEMS) begin
         pos = held_count;
         while (pos > 0 && held_vals[pos-1] > v) begin
            held_vals[pos] = held_vals[pos-1];
            pos--;
         end
         held_vals[pos] = v;
         held_count++;
      end
   endtask

   function automatic spread_word_type closing_spread();
      spread_word_type       res;
      int unsigned           k;
      logic [VALUE_BITS-1:0] d;
      k = (group_size == '0) ? 1 : group_size;   // zero acts as one
      res.too_few = held_count < k;
      res.spread  = '0;
      if (!res.too_few) begin
         res.spread = '1;
         for (int unsigned i = 0; i + k <= held_count; i++) begin
            d = held_vals[i+k-1] - held_vals[i];
            if (d < res.spread)
               res.spread = d;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      spread_word_type want;
      if (reset) begin
         held_count = 0;
         group_size = msk_pkg::GROUP_RESET;
         expected_spreads.delete();
      end else begin
         if (csr_we)
            group_size = csr_wdata;
         if (req_valid && req_ready) begin
            insert_value(req_value);
            if (req_last_value) begin
               expected_spreads = {expected_spreads, closing_spread()};
               held_count = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_spreads.size() == 0) begin
               $display("%0t: result word with none expected: spread %0d too_few %0b",
                        $time, rsp_min_spread, rsp_too_few);
               fail_count++;
            end else begin
               want = expected_spreads.pop_front();
               if (rsp_min_spread !== want.spread) begin
                  $display("%0t: min_spread mismatch: expected %0d, actual %0d",
                           $time, want.spread, rsp_min_spread);
                  fail_count++;
               end
               if (rsp_too_few !== want.too_few) begin
                  $display("%0t: too_few mismatch: expected %0b, actual %0b",
                           $time, want.too_few, rsp_too_few);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_spreads.size();
   end

endmodule

@@ verif/min_spread_of_k_values_tb.sv @@
`timescale 1ns / 1ps
module min_spread_of_k_values_tb;

   localparam int unsigned MAX_ITEMS       = 64;
   localparam int unsigned VALUE_BITS      = 16;
   localparam int unsigned GROUP_BITS      = msk_pkg::GROUP_BITS;
   localparam int          SETTLE_CYCLES   = 200;
   localparam int          ITEMS_PER_PHASE = 660;

   typedef enum {
      FILL_RANDOM,
      FILL_CLUSTER,
      FILL_EDGES,
      FILL_FALLING
   } fill_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value;
   logic                  req_last_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [VALUE_BITS-1:0] rsp_min_spread;
   logic                  rsp_too_few;
   logic                  csr_we;
   logic [GROUP_BITS-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   int                    send_idle;
   int                    recv_idle;
   int                    words_sent;

   min_spread_of_k_values #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_last_value (req_last_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_spread (rsp_min_spread),
      .rsp_too_few    (rsp_too_few),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   min_spread_checker #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_last_value (req_last_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_spread (rsp_min_spread),
      .rsp_too_few    (rsp_too_few),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("min_spread_of_k_values test failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // valid stays up across back-to-back words; it drops only on an idle gap
   task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic last);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= v;
      req_last_value <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // covers an insert or scan still running after the last result
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_group_size(input logic [GROUP_BITS-1:0] g);
      wait_drained();
      csr_wdata <= g;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_set(input int n, input fill_type fill);
      logic [VALUE_BITS-1:0] base;
      logic [VALUE_BITS-1:0] v;
      base = VALUE_BITS'($urandom);
      for (int i = 0; i < n; i++) begin
         case (fill)
            FILL_RANDOM:  v = VALUE_BITS'($urandom);
            FILL_CLUSTER: v = VALUE_BITS'(base + $urandom_range(15));
            FILL_EDGES:   v = $urandom_range(1) ? VALUE_BITS'($urandom_range(3))
                                                : '1 - VALUE_BITS'($urandom_range(3));
            default:      v = base - VALUE_BITS'(i * $urandom_range(2));
         endcase
         send_word(v, i == n - 1);
      end
   endtask

   function automatic logic [GROUP_BITS-1:0] pick_group_size();
      case ($urandom_range(9))
         0:       return '0;
         1:       return GROUP_BITS'(1);
         2:       return GROUP_BITS'(MAX_ITEMS - 1);
         3:       return GROUP_BITS'(MAX_ITEMS);
         4:       return '1;
         5:       return GROUP_BITS'($urandom_range(MAX_ITEMS + 1, 126));
         default: return GROUP_BITS'($urandom_range(2, 6));
      endcase
   endfunction

   task automatic run_phase(input int s_idle, input int r_idle);
      int start;
      int sets;
      send_idle = s_idle;
      recv_idle = r_idle;
      start     = words_sent;
      sets      = 0;
      // a full store, with up to 6 dropped words past the end
      set_group_size(GROUP_BITS'(MAX_ITEMS));
      send_set(MAX_ITEMS + $urandom_range(6), fill_type'($urandom_range(3)));
      while (words_sent - start < ITEMS_PER_PHASE) begin
         if (sets % 8 == 0)
            set_group_size(pick_group_size());
         if ($urandom_range(24) == 0)
            send_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6),
                     fill_type'($urandom_range(3)));
         else
            send_set($urandom_range(1, 12), fill_type'($urandom_range(3)));
         sets++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      req_last_value = 1'b0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      send_idle      = 37;
      recv_idle      = 65;
      words_sent     = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset group size of two
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8000, 1'b1);
      for (int i = 5; i >= 1; i--)
         send_word(VALUE_BITS'(i), i == 1);
      send_word(16'd7, 1'b0);
      send_word(16'd7, 1'b1);

      set_group_size('0);
      send_word(16'd1234, 1'b0);
      send_word(16'd4321, 1'b1);
      set_group_size(GROUP_BITS'(1));
      send_word(16'hAAAA, 1'b1);
      set_group_size(GROUP_BITS'(3));
      send_word(16'h5555, 1'b0);
      send_word(16'hAAAA, 1'b1);
      set_group_size('1);
      send_word(16'd1, 1'b0);
      send_word(16'd2, 1'b0);
      send_word(16'd3, 1'b1);

      run_phase(37, 65);
      run_phase(65, 37);
      run_phase(0, 0);

      wait_drained();
      if (fail_count == 0)
         $display("min_spread_of_k_values test passed");
      else
         $display("min_spread_of_k_values test failed");
      $finish;
   end

endmodule

@@ min_spread_of_k_values.f @@
rtl/core/msk_pkg.sv
rtl/core/msk_ram.sv
rtl/core/min_spread_of_k_values.sv
verif/min_spread_checker.sv
verif/min_spread_of_k_values_tb.sv
